### rtl/core/sawc_pkg.sv
// Shared request, response and queue entry types for the write-back cache.
package sawc_pkg;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_FILL  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_WB    = 2'd2,
      KIND_FILL  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] address;
      logic [31:0] write_data;
      logic [31:0] fill_word;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        hit;
      logic [31:0] data_word;
      logic [31:0] memory_address;
      logic        last;
   } rsp_type;

   // classified request as it sits in the queue
   typedef struct packed {
      logic        is_fill;
      logic        is_write;
      logic [31:0] address;
      logic [31:0] data;
   } job_type;

endpackage

### rtl/core/sawc_front.sv
// Front end: accepts requests, drops unused codes, queues classified jobs.
module sawc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sawc_pkg::req_type req_data,
   output sawc_pkg::job_type q_job,
   output logic              q_valid,
   input  logic              q_pop
);
   import sawc_pkg::*;

   job_type    fifo_ff [2];
   job_type    job_new;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready && (req_data.operation != OP_NONE);
   assign q_valid   = (count_ff != 2'd0);
   assign q_job     = fifo_ff[rd_ptr_ff];

   always_comb begin
      job_new.is_fill  = (req_data.operation == OP_FILL);
      job_new.is_write = (req_data.operation == OP_WRITE);
      job_new.address  = req_data.address;
      job_new.data     = job_new.is_fill ? req_data.fill_word : req_data.write_data;
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= job_new;
      end
   end

endmodule

### rtl/core/sawc_back.sv
// Back end: tag lookup, LRU ages, writeback, fill and response register.
module sawc_back #(
   parameter int SETS            = 16,
   parameter int WAYS            = 4,
   parameter int WORDS_PER_BLOCK = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  sawc_pkg::job_type q_job,
   input  logic              q_valid,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sawc_pkg::rsp_type rsp_data
);
   import sawc_pkg::*;

   localparam int SET_LOG  = $clog2(SETS);
   localparam int SET_W    = (SETS > 1) ? SET_LOG : 1;
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WORD_LOG = $clog2(WORDS_PER_BLOCK);
   localparam int WORD_W   = (WORDS_PER_BLOCK > 1) ? WORD_LOG : 1;
   localparam int OFF_BITS = WORD_LOG + 2;
   localparam int TAG_W    = 32 - OFF_BITS - SET_LOG;
   localparam int AGE_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LINE_AW  = SET_W + WAY_W + WORD_W;
   localparam logic [31:0] BLOCK_MASK = 32'(4 * WORDS_PER_BLOCK - 1);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_LOOKUP  = 8'b0000_0010,
      ST_WB_RD   = 8'b0000_0100,
      ST_WB_OUT  = 8'b0000_1000,
      ST_FREQ    = 8'b0001_0000,
      ST_INSTALL = 8'b0010_0000,
      ST_RDOUT   = 8'b0100_0000,
      ST_WROUT   = 8'b1000_0000
   } state_type;

   function automatic logic [SET_W-1:0] set_of(input logic [31:0] a);
      logic [31:0] t;
      t = (a >> OFF_BITS) & 32'(SETS - 1);
      return t[SET_W-1:0];
   endfunction

   function automatic logic [TAG_W-1:0] tag_of(input logic [31:0] a);
      logic [31:0] t;
      t = a >> (OFF_BITS + SET_LOG);
      return t[TAG_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] pos_of(input logic [31:0] a);
      logic [31:0] t;
      t = (a >> 2) & 32'(WORDS_PER_BLOCK - 1);
      return t[WORD_W-1:0];
   endfunction

   state_type         state_ff, state_in;
   job_type           job_ff, job_in;
   logic              fill_pend_ff, fill_pend_in;
   logic              pend_write_ff, pend_write_in;
   logic [31:0]       pend_addr_ff, pend_addr_in;
   logic [31:0]       pend_data_ff, pend_data_in;
   logic [WORD_W-1:0] fill_cnt_ff, fill_cnt_in;
   logic [WORD_W-1:0] wb_idx_ff, wb_idx_in;
   logic [WAY_W-1:0]  victim_ff, victim_in;
   logic [TAG_W-1:0]  wb_tag_ff, wb_tag_in;
   logic              hit_ff, hit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              valid_ff [SETS][WAYS];
   logic              valid_in [SETS][WAYS];
   logic              dirty_ff [SETS][WAYS];
   logic              dirty_in [SETS][WAYS];
   logic [AGE_W-1:0]  age_ff   [SETS][WAYS];
   logic [AGE_W-1:0]  age_in   [SETS][WAYS];

   logic [TAG_W-1:0]  tag_mem    [SETS][WAYS];
   logic [TAG_W-1:0]  tag_row_ff [WAYS];
   logic [31:0]       line_mem   [2**LINE_AW];
   logic [31:0]       line_rd_ff;

   logic               tag_re, tag_we;
   logic [SET_W-1:0]   tag_rset;
   logic [WAY_W-1:0]   tag_wway;
   logic               line_re, line_we;
   logic [LINE_AW-1:0] line_raddr, line_waddr;
   logic [31:0]        line_wdata;

   logic [SET_W-1:0]   cset, pset;
   logic [TAG_W-1:0]   ctag;
   logic [WORD_W-1:0]  cpos, ppos;
   logic               out_free;
   logic               hit_any, vic_found;
   logic [WAY_W-1:0]   hit_way, vic_way;
   logic [AGE_W-1:0]   best_age;
   logic               touch_en;
   logic [SET_W-1:0]   touch_set;
   logic [WAY_W-1:0]   touch_way;
   logic [AGE_W:0]     touch_old;

   assign cset     = set_of(job_ff.address);
   assign ctag     = tag_of(job_ff.address);
   assign cpos     = pos_of(job_ff.address);
   assign pset     = set_of(pend_addr_ff);
   assign ppos     = pos_of(pend_addr_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // hit search and victim choice over the ways of the current set
   always_comb begin
      hit_any   = 1'b0;
      hit_way   = '0;
      vic_found = 1'b0;
      vic_way   = '0;
      best_age  = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (!hit_any && valid_ff[cset][i] && (tag_row_ff[i] == ctag)) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(i);
         end
         if (!vic_found) begin
            if (!valid_ff[cset][i]) begin
               vic_found = 1'b1;
               vic_way   = WAY_W'(i);
            end else if (age_ff[cset][i] >= best_age) begin
               best_age = age_ff[cset][i];
               vic_way  = WAY_W'(i);
            end
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      fill_pend_in  = fill_pend_ff;
      pend_write_in = pend_write_ff;
      pend_addr_in  = pend_addr_ff;
      pend_data_in  = pend_data_ff;
      fill_cnt_in   = fill_cnt_ff;
      wb_idx_in     = wb_idx_ff;
      victim_in     = victim_ff;
      wb_tag_in     = wb_tag_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      valid_in      = valid_ff;
      dirty_in      = dirty_ff;
      age_in        = age_ff;
      q_pop         = 1'b0;
      tag_re        = 1'b0;
      tag_rset      = set_of(q_job.address);
      tag_we        = 1'b0;
      tag_wway      = victim_ff;
      line_re       = 1'b0;
      line_raddr    = {pset, victim_ff, ppos};
      line_we       = 1'b0;
      line_waddr    = {pset, victim_ff, fill_cnt_ff};
      line_wdata    = q_job.data;
      touch_en      = 1'b0;
      touch_set     = cset;
      touch_way     = hit_way;
      touch_old     = {1'b0, age_ff[cset][hit_way]};

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               job_in = q_job;
               if (q_job.is_fill) begin
                  if (fill_pend_ff) begin
                     line_we = 1'b1;
                     if (fill_cnt_ff == WORD_W'(WORDS_PER_BLOCK - 1)) begin
                        fill_cnt_in = '0;
                        state_in    = ST_INSTALL;
                     end else begin
                        fill_cnt_in = fill_cnt_ff + 1'b1;
                     end
                  end
               end else if (!fill_pend_ff) begin
                  tag_re   = 1'b1;
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            if (hit_any) begin
               touch_en = 1'b1;
               hit_in   = 1'b1;
               if (job_ff.is_write) begin
                  dirty_in[cset][hit_way] = 1'b1;
                  line_we    = 1'b1;
                  line_waddr = {cset, hit_way, cpos};
                  line_wdata = job_ff.data;
                  state_in   = ST_WROUT;
               end else begin
                  line_re    = 1'b1;
                  line_raddr = {cset, hit_way, cpos};
                  state_in   = ST_RDOUT;
               end
            end else begin
               if (valid_ff[cset][vic_way] && dirty_ff[cset][vic_way]) begin
                  wb_tag_in = tag_row_ff[vic_way];
                  wb_idx_in = '0;
                  state_in  = ST_WB_RD;
               end else begin
                  state_in  = ST_FREQ;
               end
               valid_in[cset][vic_way] = 1'b0;
               dirty_in[cset][vic_way] = 1'b0;
               victim_in     = vic_way;
               fill_pend_in  = 1'b1;
               fill_cnt_in   = '0;
               pend_write_in = job_ff.is_write;
               pend_addr_in  = job_ff.address;
               pend_data_in  = job_ff.data;
            end
         end
         ST_WB_RD: begin
            line_re    = 1'b1;
            line_raddr = {pset, victim_ff, wb_idx_ff};
            state_in   = ST_WB_OUT;
         end
         ST_WB_OUT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.kind           = KIND_WB;
               rsp_in.hit            = 1'b0;
               rsp_in.data_word      = line_rd_ff;
               rsp_in.memory_address = (32'(wb_tag_ff) << (OFF_BITS + SET_LOG))
                                     | (32'(pset) << OFF_BITS)
                                     | (32'(wb_idx_ff) << 2);
               rsp_in.last           = 1'b0;
               if (wb_idx_ff == WORD_W'(WORDS_PER_BLOCK - 1)) begin
                  state_in = ST_FREQ;
               end else begin
                  wb_idx_in = wb_idx_ff + 1'b1;
                  state_in  = ST_WB_RD;
               end
            end
         end
         ST_FREQ: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.kind           = KIND_FILL;
               rsp_in.hit            = 1'b0;
               rsp_in.data_word      = '0;
               rsp_in.memory_address = pend_addr_ff & ~BLOCK_MASK;
               rsp_in.last           = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         ST_INSTALL: begin
            valid_in[pset][victim_ff] = 1'b1;
            dirty_in[pset][victim_ff] = pend_write_ff;
            tag_we       = 1'b1;
            touch_en     = 1'b1;
            touch_set    = pset;
            touch_way    = victim_ff;
            touch_old    = (AGE_W + 1)'(WAYS);
            fill_pend_in = 1'b0;
            hit_in       = 1'b0;
            if (pend_write_ff) begin
               line_we    = 1'b1;
               line_waddr = {pset, victim_ff, ppos};
               line_wdata = pend_data_ff;
               state_in   = ST_WROUT;
            end else begin
               line_re    = 1'b1;
               state_in   = ST_RDOUT;
            end
         end
         ST_RDOUT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.kind           = KIND_READ;
               rsp_in.hit            = hit_ff;
               rsp_in.data_word      = line_rd_ff;
               rsp_in.memory_address = '0;
               rsp_in.last           = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         ST_WROUT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.kind           = KIND_WRITE;
               rsp_in.hit            = hit_ff;
               rsp_in.data_word      = '0;
               rsp_in.memory_address = '0;
               rsp_in.last           = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // LRU ages: accessed way to zero, younger valid ways age by one
      if (touch_en) begin
         for (int i = 0; i < WAYS; i++) begin
            if (valid_in[touch_set][i]) begin
               if (WAY_W'(i) == touch_way) begin
                  age_in[touch_set][i] = '0;
               end else if ({1'b0, age_ff[touch_set][i]} < touch_old) begin
                  age_in[touch_set][i] = age_ff[touch_set][i] + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_pend_ff  <= 1'b0;
         pend_write_ff <= 1'b0;
         fill_cnt_ff   <= '0;
         wb_idx_ff     <= '0;
         victim_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
               valid_ff[s][w] <= 1'b0;
               dirty_ff[s][w] <= 1'b0;
               age_ff[s][w]   <= '0;
            end
         end
      end else begin
         state_ff      <= state_in;
         fill_pend_ff  <= fill_pend_in;
         pend_write_ff <= pend_write_in;
         fill_cnt_ff   <= fill_cnt_in;
         wb_idx_ff     <= wb_idx_in;
         victim_ff     <= victim_in;
         rsp_valid_ff  <= rsp_valid_in;
         valid_ff      <= valid_in;
         dirty_ff      <= dirty_in;
         age_ff        <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
      wb_tag_ff    <= wb_tag_in;
      hit_ff       <= hit_in;
      rsp_ff       <= rsp_in;
   end

   // tag store: one way written, one set row read
   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[pset][tag_wway] <= tag_of(pend_addr_ff);
      end
      if (tag_re) begin
         for (int i = 0; i < WAYS; i++) begin
            tag_row_ff[i] <= tag_mem[tag_rset][i];
         end
      end
   end

   // data store: one write and one read port
   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[line_waddr] <= line_wdata;
      end
      if (line_re) begin
         line_rd_ff <= line_mem[line_raddr];
      end
   end

endmodule

### rtl/core/set_assoc_writeback_cache.sv
// Top level of the set-associative write-back cache with LRU replacement.
//
//   channel   ports                           direction  payload
//   request   req_valid req_ready req_data    in         sawc_pkg::req_type
//   response  rsp_valid rsp_ready rsp_data    out        sawc_pkg::rsp_type
//
// A hit passes through the back end as dequeue, tag compare, then response.
// A miss adds one data store read and one response per writeback word, then the
// fill request; each fill word is written through the data store write port.
// Reset clears valid, dirty and age state at once; no clearing pass is needed.
// A two-entry request queue keeps accepting until full while the response register stalls.
// SETS and WORDS_PER_BLOCK must be powers of two.
module set_assoc_writeback_cache #(
   parameter int SETS            = 16,
   parameter int WAYS            = 4,
   parameter int WORDS_PER_BLOCK = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sawc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sawc_pkg::rsp_type rsp_data
);
   import sawc_pkg::*;

   job_type  q_job;
   logic     q_valid;
   logic     q_pop;

   sawc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_job     (q_job),
      .q_valid   (q_valid),
      .q_pop     (q_pop)
   );

   sawc_back #(
      .SETS            (SETS),
      .WAYS            (WAYS),
      .WORDS_PER_BLOCK (WORDS_PER_BLOCK)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_job     (q_job),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_wb_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_WB) |-> (!rsp_data.last && !rsp_data.hit))
      else $error("writeback word flagged last or hit");

   a_fill_req_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_FILL) |-> (rsp_data.last && !rsp_data.hit))
      else $error("fill request not last or flagged hit");

endmodule

### test/testbench.sv
// Self-checking testbench for the set-associative write-back cache.
`timescale 1ns / 100ps

module testbench;
   import sawc_pkg::*;

   localparam int SETS = 16;
   localparam int WAYS = 4;
   localparam int WPB = 8;
   localparam int BLOCK_BYTES = 4 * WPB;
   localparam int IDLE_LIMIT = 5000;
   localparam int ITEMS = 460;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   set_assoc_writeback_cache #(.SETS(SETS), .WAYS(WAYS), .WORDS_PER_BLOCK(WPB)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // cache shadow state
   bit          line_valid [SETS*WAYS];
   bit          line_dirty [SETS*WAYS];
   int unsigned line_age   [SETS*WAYS];
   logic [31:0] line_tag   [SETS*WAYS];
   logic [31:0] line_words [SETS*WAYS*WPB];
   bit          miss_open;
   bit          miss_write;
   logic [31:0] miss_addr;
   logic [31:0] miss_data;
   int unsigned fill_pos;
   int unsigned miss_way;

   rsp_type expected_rsps[$];
   int  errors = 0;
   int  sent = 0;
   bit  quiet_idle = 1'b0;
   int  stalled = 0;

   // recently used addresses so random traffic hits and evicts
   logic [31:0] hot_addrs[$];

   function automatic rsp_type make_rsp(kind_type k, bit h, logic [31:0] d,
                                        logic [31:0] m, bit l);
      rsp_type r;
      r.kind = k; r.hit = h; r.data_word = d; r.memory_address = m; r.last = l;
      return r;
   endfunction

   function automatic void age_lines(int unsigned s, int unsigned w, int unsigned old_age);
      int unsigned ln;
      for (int i = 0; i < WAYS; i++) begin
         ln = s * WAYS + i;
         if (line_valid[ln]) begin
            if (i == w) line_age[ln] = 0;
            else if (line_age[ln] < old_age) line_age[ln]++;
         end
      end
   endfunction

   function automatic void predict_cache(req_type rq);
      int unsigned s, pos, ln, v, best;
      logic [31:0] tg, base;
      if (rq.operation == OP_FILL) begin
         if (!miss_open) return;
         s = (miss_addr / BLOCK_BYTES) % SETS;
         ln = s * WAYS + miss_way;
         line_words[ln*WPB + fill_pos] = rq.fill_word;
         fill_pos++;
         if (fill_pos < WPB) return;
         pos = (miss_addr % BLOCK_BYTES) / 4;
         line_valid[ln] = 1'b1;
         line_dirty[ln] = miss_write;
         line_tag[ln] = miss_addr / (SETS * BLOCK_BYTES);
         age_lines(s, miss_way, WAYS);
         miss_open = 1'b0;
         fill_pos = 0;
         if (miss_write) begin
            line_words[ln*WPB + pos] = miss_data;
            expected_rsps.push_back(make_rsp(KIND_WRITE, 0, '0, '0, 1));
         end else begin
            expected_rsps.push_back(make_rsp(KIND_READ, 0, line_words[ln*WPB + pos], '0, 1));
         end
         return;
      end
      if (rq.operation == OP_NONE || miss_open) return;
      s = (rq.address / BLOCK_BYTES) % SETS;
      tg = rq.address / (SETS * BLOCK_BYTES);
      pos = (rq.address % BLOCK_BYTES) / 4;
      for (int i = 0; i < WAYS; i++) begin
         ln = s * WAYS + i;
         if (line_valid[ln] && line_tag[ln] == tg) begin
            age_lines(s, i, line_age[ln]);
            if (rq.operation == OP_WRITE) begin
               line_dirty[ln] = 1'b1;
               line_words[ln*WPB + pos] = rq.write_data;
               expected_rsps.push_back(make_rsp(KIND_WRITE, 1, '0, '0, 1));
            end else begin
               expected_rsps.push_back(make_rsp(KIND_READ, 1, line_words[ln*WPB + pos], '0, 1));
            end
            return;
         end
      end
      v = 0; best = 0;
      for (int i = 0; i < WAYS; i++) begin
         ln = s * WAYS + i;
         if (!line_valid[ln]) begin
            v = i;
            break;
         end
         if (line_age[ln] >= best) begin
            best = line_age[ln];
            v = i;
         end
      end
      ln = s * WAYS + v;
      if (line_valid[ln] && line_dirty[ln]) begin
         base = (line_tag[ln] * SETS + s) * BLOCK_BYTES;
         for (int i = 0; i < WPB; i++)
            expected_rsps.push_back(make_rsp(KIND_WB, 0, line_words[ln*WPB + i],
                                             base + 4 * i, 0));
      end
      line_valid[ln] = 1'b0;
      line_dirty[ln] = 1'b0;
      miss_way = v;
      expected_rsps.push_back(make_rsp(KIND_FILL, 0, '0, rq.address - (rq.address % BLOCK_BYTES), 1));
      miss_open = 1'b1;
      miss_write = (rq.operation == OP_WRITE);
      miss_addr = rq.address;
      miss_data = rq.write_data;
      fill_pos = 0;
   endfunction

   function automatic req_type make_req(op_type op, logic [31:0] a, logic [31:0] w,
                                        logic [31:0] f);
      req_type r;
      r.operation = op; r.address = a; r.write_data = w; r.fill_word = f;
      return r;
   endfunction

   // valid stays up after the accepting edge; the next request or an idle
   // cycle in the same time step replaces it
   task automatic send_request(req_type rq);
      if (!quiet_idle) begin
         while ($urandom_range(99) < 9) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      predict_cache(rq);
      if (rq.operation != OP_NONE) hot_addrs.push_back(rq.address);
      if (hot_addrs.size() > 12) void'(hot_addrs.pop_front());
   endtask

   task automatic send_fill_words();
      while (miss_open)
         send_request(make_req(OP_FILL, $urandom, $urandom, $urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // response side: random stalls, compare against oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response kind=%0d", rsp_data.kind);
            errors++;
         end else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_data.kind !== e.kind) begin
               $error("kind exp %0d got %0d", e.kind, rsp_data.kind); errors++;
            end
            if (rsp_data.hit !== e.hit) begin
               $error("hit exp %0d got %0d", e.hit, rsp_data.hit); errors++;
            end
            if (rsp_data.data_word !== e.data_word) begin
               $error("data_word exp %h got %h", e.data_word, rsp_data.data_word); errors++;
            end
            if (rsp_data.memory_address !== e.memory_address) begin
               $error("memory_address exp %h got %h", e.memory_address,
                      rsp_data.memory_address); errors++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_data.last); errors++;
            end
         end
      end
      rsp_ready <= reset ? 1'b0 : (quiet_idle || $urandom_range(99) >= 9);
   end

   // watchdog on cycles with no accepted request or response
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) stalled <= 0;
      else stalled <= stalled + 1;
      if (stalled >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   localparam int DIRECTED = 20;
   req_type directed_reqs [DIRECTED];

   initial begin
      req_type     rq;
      logic [31:0] a;
      int          pick;
      // sets 0 and 15, five tags each to force dirty evictions; extremes of fields
      directed_reqs[0]  = make_req(OP_FILL,  32'h0000_0000, 32'h0, 32'hFFFF_FFFF); // stray fill
      directed_reqs[1]  = make_req(OP_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      directed_reqs[2]  = make_req(OP_READ,  32'h0000_0000, 32'h0, 32'h0);
      directed_reqs[3]  = make_req(OP_WRITE, 32'h0000_0004, 32'hFFFF_FFFF, 32'h0);
      directed_reqs[4]  = make_req(OP_READ,  32'h0000_0004, 32'h0, 32'h0);
      directed_reqs[5]  = make_req(OP_WRITE, 32'h0000_0203, 32'hA5A5_5A5A, 32'h0);
      directed_reqs[6]  = make_req(OP_READ,  32'h0000_0400, 32'h0, 32'h0);
      directed_reqs[7]  = make_req(OP_READ,  32'h0000_0600, 32'h0, 32'h0);
      directed_reqs[8]  = make_req(OP_READ,  32'h0000_0800, 32'h0, 32'h0); // dirty victim
      directed_reqs[9]  = make_req(OP_READ,  32'h0000_0001, 32'h0, 32'h0);
      directed_reqs[10] = make_req(OP_WRITE, 32'hFFFF_FFFF, 32'h0, 32'h0);
      directed_reqs[11] = make_req(OP_READ,  32'hFFFF_FFFC, 32'h0, 32'h0);
      directed_reqs[12] = make_req(OP_READ,  32'hFFFF_FDE0, 32'h0, 32'h0);
      directed_reqs[13] = make_req(OP_READ,  32'hFFFF_FBE0, 32'h0, 32'h0);
      directed_reqs[14] = make_req(OP_READ,  32'hFFFF_F9E0, 32'h0, 32'h0);
      directed_reqs[15] = make_req(OP_READ,  32'hFFFF_F7E0, 32'h0, 32'h0);
      directed_reqs[16] = make_req(OP_READ,  32'h0000_0208, 32'h0, 32'h0);
      directed_reqs[17] = make_req(OP_WRITE, 32'h0000_0208, 32'h1234_5678, 32'h0);
      directed_reqs[18] = make_req(OP_READ,  32'h0000_0208, 32'h0, 32'h0);
      directed_reqs[19] = make_req(OP_FILL,  32'h0, 32'h0, 32'h0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED; i++) begin
         send_request(directed_reqs[i]);
         if (miss_open) begin
            // access during a pending fill is dropped
            if (i == 6) send_request(make_req(OP_WRITE, 32'h40, 32'h1, 32'h0));
            send_fill_words();
         end
      end
      wait_drained();

      // a miss brings eight fill words, so the loop runs on the request count
      for (int n = 0; sent < ITEMS; n++) begin
         quiet_idle = (n >= 20 && n < 45);
         if (n == 50) wait_drained();
         pick = $urandom_range(99);
         if (pick < 60 && hot_addrs.size() > 0)
            a = hot_addrs[$urandom_range(hot_addrs.size() - 1)] ^ ($urandom_range(7) << 2);
         else if (pick < 85)
            a = {3'($urandom_range(7)), 20'h0, 9'($urandom_range(511))}
                ^ ($urandom & 32'hFFFF_F000);
         else
            a = $urandom;
         pick = $urandom_range(99);
         if (pick < 4) rq = make_req(OP_NONE, a, $urandom, $urandom);
         else if (pick < 8) rq = make_req(OP_FILL, a, $urandom, $urandom);
         else rq = make_req(pick < 50 ? OP_WRITE : OP_READ, a, $urandom, $urandom);
         send_request(rq);
         if (miss_open) begin
            if ($urandom_range(9) == 0)
               send_request(make_req(OP_READ, $urandom, $urandom, $urandom));
            send_fill_words();
         end
      end
      quiet_idle = 1'b0;

      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      for (int i = 0; i < SETS*WAYS; i++) begin
         line_valid[i] = 0; line_dirty[i] = 0; line_age[i] = 0; line_tag[i] = '0;
      end
      miss_open = 0; miss_write = 0; miss_addr = '0; miss_data = '0;
      fill_pos = 0; miss_way = 0;
   end
endmodule
